// ===== src/block_disk_latch_controller_top_macros.svh =====
// Assertion macros for the block disk latch controller.
// Used by block_disk_latch_controller_top; expects clk_i and rst_ni in scope.
`ifndef BLOCK_DISK_LATCH_CONTROLLER_TOP_MACROS_SVH
`define BLOCK_DISK_LATCH_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define BDLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bdlc_pkg.sv =====
// Package for the block disk latch controller: sizes, register and command
// codes, sequencer states and the disk store request type. No dependencies.
`timescale 1ns / 1ps

package bdlc_pkg;

  localparam int BUFFER_BYTES = 512;
  // blocks per unit; a power of two, so the block modulo is a mask
  localparam int DISK_BLOCKS  = 128;

  localparam int IDX_W      = $clog2(BUFFER_BYTES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int STORE_ROWS = 2 * DISK_BLOCKS;
  localparam int ROW_W      = $clog2(STORE_ROWS);
  localparam int STORE_AW   = ROW_W + IDX_W;
  localparam int STORE_BYTES = STORE_ROWS * BUFFER_BYTES;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(BUFFER_BYTES);

  // register offsets
  localparam logic [3:0] REG_WR_DATA  = 4'd0;
  localparam logic [3:0] REG_WR_PEND  = 4'd1;
  localparam logic [3:0] REG_RD_DATA  = 4'd2;
  localparam logic [3:0] REG_RD_CLR   = 4'd3;
  localparam logic [3:0] REG_POLL_CMD = 4'd4;
  localparam logic [3:0] REG_POLL_WR  = 4'd5;
  localparam logic [3:0] REG_POLL_RD  = 4'd6;
  localparam logic [3:0] REG_CMD      = 4'd7;

  // command codes (low nibble of the command byte)
  localparam logic [3:0] CMD_IDLE      = 4'd0;
  localparam logic [3:0] CMD_SIZE      = 4'd1;
  localparam logic [3:0] CMD_SET_BLOCK = 4'd2;
  localparam logic [3:0] CMD_READ      = 4'd3;
  localparam logic [3:0] CMD_WRITE     = 4'd4;
  localparam logic [3:0] CMD_CLEAR     = 4'd5;
  localparam logic [3:0] CMD_READ0     = 4'd6;
  localparam logic [3:0] CMD_FIFO_RST  = 4'd7;
  localparam logic [3:0] CMD_STREAM    = 4'd8;

  localparam logic [7:0] CMDB_NONE   = 8'h00;
  localparam logic [7:0] CMDB_STREAM = 8'h08;
  localparam logic [7:0] FLAG_SET    = 8'h80;
  localparam logic [7:0] FLAG_CLR    = 8'h00;

  // configuration register indexes
  localparam logic CFG_UNIT0 = 1'b0;
  localparam logic CFG_UNIT1 = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SIZE_HI,
    S_SB_LO,
    S_SB_HI,
    S_COPY_IN,
    S_COPY_OUT,
    S_ZERO,
    S_STREAM
  } state_e;

  typedef struct packed {
    logic                rd;
    logic                wr;
    logic                set_valid;
    logic                clr_valid;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          wdata;
  } store_req_t;

  // disk store row of a unit and block number
  function automatic logic [ROW_W-1:0] row_of(input logic unit1, input logic [15:0] blk);
    logic [16:0] m;
    m = {1'b0, blk} % 17'(DISK_BLOCKS);
    return unit1 ? ROW_W'(DISK_BLOCKS) + ROW_W'(m) : ROW_W'(m);
  endfunction

endpackage

// ===== src/bdlc_store.sv =====
// Disk image store: one synchronous byte memory plus a valid bit per block.
// Depends on bdlc_pkg. A block that is not valid reads back as zeros.
`timescale 1ns / 1ps

module bdlc_store import bdlc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0]            mem [STORE_BYTES];
  logic [STORE_ROWS-1:0] valid_q;
  logic [7:0]            mem_q;
  logic                  vld_q;
  logic [ROW_W-1:0]      row;

  assign row = req_i.addr[STORE_AW-1:IDX_W];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      mem_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (req_i.set_valid) begin
        valid_q[row] <= 1'b1;
      end else if (req_i.clr_valid) begin
        valid_q[row] <= 1'b0;
      end
      if (req_i.rd) begin
        vld_q <= valid_q[row];
      end
    end
  end

  assign rdata_o = vld_q ? mem_q : 8'h00;

endmodule

// ===== src/block_disk_latch_controller_top.sv =====
// Block disk latch controller, top level: register window, 512-byte buffer
// memory and command sequencer. Depends on bdlc_pkg, bdlc_store and the macros header.
// Register accesses and single-step polls report from idle; size, set block and stream
// run extra sequencer states; read/write block and clear move one byte per cycle.
// Throughput: one transaction at a time; the next is taken once busy_o drops, so plain
// accesses run 1/cycle; no receiver stall. Reset: buffer clear, busy_o high.
`timescale 1ns / 1ps

module block_disk_latch_controller_top import bdlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  reg_addr_i,
  input  logic [7:0]  bus_data_i,
  // result channel
  output logic        done_o,
  output logic [7:0]  read_data_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  `include "block_disk_latch_controller_top_macros.svh"

  // sequencer and register window state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       wr_latch_q, wr_latch_d;
  logic [7:0]       rd_latch_q, rd_latch_d;
  logic             wr_pend_q, wr_pend_d;
  logic             rd_ready_q, rd_ready_d;
  logic             cmd_pend_q, cmd_pend_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      cur_blk_q, cur_blk_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             done_q, done_d;
  logic [7:0]       result_q, result_d;
  logic [15:0]      unit0_cnt_q, unit1_cnt_q;

  // buffer memory ports
  logic [7:0]       buf_mem [BUFFER_BYTES];
  logic             buf_we, buf_re;
  logic [IDX_W-1:0] buf_waddr, buf_raddr;
  logic [7:0]       buf_wdata, buf_rdata_q;

  store_req_t       store_req;
  logic [7:0]       store_rdata;

  logic             accept, poll;
  logic [3:0]       cmd_code;
  logic             unit1;
  logic [15:0]      size_cnt;
  logic [7:0]       flag;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign poll     = (reg_addr_i == REG_POLL_CMD) || (reg_addr_i == REG_POLL_WR) ||
                    (reg_addr_i == REG_POLL_RD);
  assign cmd_code = cmd_q[3:0];
  assign unit1    = cmd_q[7];
  assign size_cnt = unit1 ? unit1_cnt_q : unit0_cnt_q;

  // flag returned by the polled status register
  always_comb begin
    flag = FLAG_CLR;
    if ((reg_addr_i == REG_POLL_CMD) && cmd_pend_q) flag = FLAG_SET;
    if ((reg_addr_i == REG_POLL_WR) && wr_pend_q)   flag = FLAG_SET;
    if ((reg_addr_i == REG_POLL_RD) && rd_ready_q)  flag = FLAG_SET;
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (cnt_q[IDX_W-1:0] == IDX_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept && poll) begin
          unique case (cmd_code)
            CMD_SIZE:             state_d = S_SIZE_HI;
            CMD_SET_BLOCK:        state_d = S_SB_LO;
            CMD_READ, CMD_READ0:  state_d = S_COPY_IN;
            CMD_WRITE:            state_d = S_COPY_OUT;
            CMD_CLEAR:            state_d = S_ZERO;
            CMD_STREAM: begin
              if (!rd_ready_q) state_d = S_STREAM;
            end
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_SIZE_HI, S_SB_HI, S_STREAM: state_d = S_IDLE;
      S_SB_LO:                      state_d = S_SB_HI;
      S_COPY_IN, S_COPY_OUT: begin
        if (cnt_q == CNT_END) state_d = S_IDLE;
      end
      S_ZERO: begin
        if (cnt_q[IDX_W-1:0] == IDX_LAST) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------- outputs and data
  always_comb begin
    cnt_d      = cnt_q;
    wr_latch_d = wr_latch_q;
    rd_latch_d = rd_latch_q;
    wr_pend_d  = wr_pend_q;
    rd_ready_d = rd_ready_q;
    cmd_pend_d = cmd_pend_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    cur_blk_d  = cur_blk_q;
    row_d      = row_q;
    done_d     = 1'b0;
    result_d   = result_q;
    buf_we     = 1'b0;
    buf_re     = 1'b0;
    buf_waddr  = idx_q;
    buf_raddr  = idx_q;
    buf_wdata  = 8'h00;
    store_req  = '0;

    unique case (state_q)
      S_INIT: begin
        // zero the buffer once after reset
        buf_we    = 1'b1;
        buf_waddr = cnt_q[IDX_W-1:0];
        cnt_d     = cnt_q + 1'b1;
      end

      S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          done_d   = !poll;
          result_d = 8'h00;
          unique case (reg_addr_i)
            REG_WR_DATA: wr_latch_d = bus_data_i;
            REG_WR_PEND: wr_pend_d  = 1'b1;
            REG_RD_DATA: result_d   = rd_latch_q;
            REG_RD_CLR:  rd_ready_d = 1'b0;
            REG_CMD: begin
              cmd_d      = bus_data_i;
              idx_d      = '0;
              cmd_pend_d = 1'b1;
              wr_pend_d  = 1'b0;
              rd_ready_d = 1'b0;
            end
            REG_POLL_CMD, REG_POLL_WR, REG_POLL_RD: begin
              result_d = flag;
              // one step of the latched command
              unique case (cmd_code)
                CMD_IDLE: begin
                  done_d = 1'b1;
                  if (wr_pend_q) begin
                    buf_we    = 1'b1;
                    buf_wdata = wr_latch_q;
                    wr_pend_d = 1'b0;
                    idx_d     = idx_q + 1'b1;
                  end
                end
                CMD_SIZE: begin
                  buf_we    = 1'b1;
                  buf_waddr = '0;
                  buf_wdata = size_cnt[7:0];
                end
                CMD_SET_BLOCK: begin
                  buf_re    = 1'b1;
                  buf_raddr = '0;
                end
                CMD_READ: row_d = row_of(unit1, cur_blk_q);
                CMD_READ0: begin
                  cur_blk_d = '0;
                  row_d     = row_of(unit1, 16'h0000);
                end
                CMD_WRITE: begin
                  row_d               = row_of(unit1, cur_blk_q);
                  store_req.set_valid = 1'b1;
                  store_req.addr      = {row_d, IDX_W'(0)};
                end
                CMD_CLEAR: begin
                  // any high-nibble bit picks unit one here
                  row_d               = row_of(|cmd_q[7:4], cur_blk_q);
                  store_req.clr_valid = 1'b1;
                  store_req.addr      = {row_d, IDX_W'(0)};
                end
                CMD_FIFO_RST: begin
                  done_d = 1'b1;
                  if (cmd_pend_q) begin
                    cmd_d      = CMDB_NONE;
                    cmd_pend_d = 1'b0;
                  end
                end
                CMD_STREAM: begin
                  if (rd_ready_q) begin
                    done_d = 1'b1;
                  end else begin
                    buf_re = 1'b1;
                  end
                end
                default: done_d = 1'b1;
              endcase
            end
            default: ;
          endcase
        end
      end

      S_SIZE_HI: begin
        buf_we     = 1'b1;
        buf_waddr  = IDX_W'(1);
        buf_wdata  = size_cnt[15:8];
        cmd_d      = CMDB_STREAM;
        cmd_pend_d = 1'b0;
        done_d     = 1'b1;
      end

      S_SB_LO: begin
        cur_blk_d[7:0] = buf_rdata_q;
        buf_re         = 1'b1;
        buf_raddr      = IDX_W'(1);
      end

      S_SB_HI: begin
        cur_blk_d[15:8] = buf_rdata_q;
        buf_we          = 1'b1;
        buf_waddr       = '0;
        cmd_d           = CMDB_STREAM;
        cmd_pend_d      = 1'b0;
        done_d          = 1'b1;
      end

      S_COPY_IN: begin
        // read store byte n, write buffer byte n-1
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != CNT_END) begin
          store_req.rd   = 1'b1;
          store_req.addr = {row_q, cnt_q[IDX_W-1:0]};
        end
        if (cnt_q != '0) begin
          buf_we    = 1'b1;
          buf_waddr = IDX_W'(cnt_q - 1'b1);
          buf_wdata = store_rdata;
        end
        if (cnt_q == CNT_END) begin
          cmd_d      = CMDB_STREAM;
          cmd_pend_d = 1'b0;
          done_d     = 1'b1;
        end
      end

      S_COPY_OUT: begin
        // read buffer byte n, write store byte n-1
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != CNT_END) begin
          buf_re    = 1'b1;
          buf_raddr = cnt_q[IDX_W-1:0];
        end
        if (cnt_q != '0) begin
          store_req.wr    = 1'b1;
          store_req.addr  = {row_q, IDX_W'(cnt_q - 1'b1)};
          store_req.wdata = buf_rdata_q;
        end
        if (cnt_q == CNT_END) begin
          cmd_d      = CMDB_NONE;
          cmd_pend_d = 1'b0;
          done_d     = 1'b1;
        end
      end

      S_ZERO: begin
        buf_we    = 1'b1;
        buf_waddr = cnt_q[IDX_W-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[IDX_W-1:0] == IDX_LAST) begin
          cmd_d      = CMDB_STREAM;
          cmd_pend_d = 1'b0;
          done_d     = 1'b1;
        end
      end

      S_STREAM: begin
        rd_latch_d = buf_rdata_q;
        rd_ready_d = 1'b1;
        idx_d      = idx_q + 1'b1;
        done_d     = 1'b1;
      end

      default: ;
    endcase
  end

  // ------------------------------------------------------------------- buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    if (buf_re) begin
      buf_rdata_q <= buf_mem[buf_raddr];
    end
  end

  bdlc_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      wr_latch_q  <= 8'h00;
      rd_latch_q  <= 8'h00;
      wr_pend_q   <= 1'b0;
      rd_ready_q  <= 1'b0;
      cmd_pend_q  <= 1'b0;
      cmd_q       <= CMDB_NONE;
      idx_q       <= '0;
      cur_blk_q   <= '0;
      done_q      <= 1'b0;
      unit0_cnt_q <= 16'd128;
      unit1_cnt_q <= 16'd128;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      wr_latch_q <= wr_latch_d;
      rd_latch_q <= rd_latch_d;
      wr_pend_q  <= wr_pend_d;
      rd_ready_q <= rd_ready_d;
      cmd_pend_q <= cmd_pend_d;
      cmd_q      <= cmd_d;
      idx_q      <= idx_d;
      cur_blk_q  <= cur_blk_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_UNIT0: unit0_cnt_q <= cfg_wdata_i;
          CFG_UNIT1: unit1_cnt_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    result_q <= result_d;
  end

  assign done_o      = done_q;
  assign read_data_o = result_q;

  // --------------------------------------------------------------- assertions
  // a result only shows once the sequencer is back and free
  `BDLC_ASSERT_NOW(a_done_idle, done_o, state_q == S_IDLE, "result strobe while busy")
  // block copy counter never runs past the end of the buffer
  `BDLC_ASSERT_NOW(a_copy_cnt, (state_q == S_COPY_IN) || (state_q == S_COPY_OUT),
                   cnt_q <= CNT_END, "copy counter overran")
  // the last copy cycle retires the command and reports
  `BDLC_ASSERT_NEXT(a_copy_end,
                    ((state_q == S_COPY_IN) || (state_q == S_COPY_OUT)) && (cnt_q == CNT_END),
                    done_o && !cmd_pend_q, "block copy did not complete")

endmodule

// ===== tb/tb_block_disk_latch_controller_top.sv =====
// Self-checking testbench for block_disk_latch_controller_top: register window,
// command sequencing and disk store contents, checked against an in-bench predictor.
// Depends on bdlc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_block_disk_latch_controller_top;
  import bdlc_pkg::*;

  // stop after roughly this many register transactions (offsets 8..15 not counted)
  localparam int ITEM_TARGET    = 1150;
  localparam int PHASES         = 5;
  // idle cycles after the last result; longest op is a block copy
  localparam int DRAIN_CYCLES   = 600;
  // longest legal quiet stretch is the final drain after the last result
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic        busy_o;
  logic [3:0]  reg_addr_i  = '0;
  logic [7:0]  bus_data_i  = '0;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  int n_items      = 0;
  int stall_cycles = 0;
  bit gaps_on      = 1'b0;

  // Shadow of the controller: latches, flags, buffer and the full disk image.
  // Each accepted transaction yields exactly one read_data byte.
  class disk_latch_scoreboard;
    logic [7:0]       wr_latch, rd_latch, cmd_byte;
    logic             wr_pend, rd_ready, cmd_pend;
    logic [IDX_W-1:0] idx;
    logic [15:0]      cur_block;
    logic [15:0]      block_count [2];
    logic [7:0]       buffer [BUFFER_BYTES];
    logic [7:0]       disk [STORE_BYTES];
    logic [7:0]       read_data_due [$];
    int               errors, results, transfers;

    function new();
      wr_latch  = '0;
      rd_latch  = '0;
      cmd_byte  = '0;
      wr_pend   = 1'b0;
      rd_ready  = 1'b0;
      cmd_pend  = 1'b0;
      idx       = '0;
      cur_block = '0;
      block_count[0] = 16'd128;
      block_count[1] = 16'd128;
      foreach (buffer[i]) buffer[i] = '0;
      foreach (disk[i]) disk[i] = '0;
      errors    = 0;
      results   = 0;
      transfers = 0;
    endfunction

    function void set_count(input logic unit, input logic [15:0] value);
      block_count[unit] = value;
    endfunction

    // byte offset of the current block; block number wraps at the disk depth
    function int block_base(input logic unit1);
      return ((unit1 ? DISK_BLOCKS : 0) + int'(cur_block) % DISK_BLOCKS) * BUFFER_BYTES;
    endfunction

    function void retire(input logic [7:0] next);
      cmd_byte = next;
      cmd_pend = 1'b0;
    endfunction

    // one step of the latched command, run by any status poll
    function void run_command();
      logic [15:0] cnt;
      int          base;
      case (cmd_byte[3:0])
        CMD_IDLE: if (wr_pend) begin
          buffer[idx] = wr_latch;
          wr_pend     = 1'b0;
          idx         = idx + 1'b1;
        end
        CMD_SIZE: begin
          cnt       = block_count[cmd_byte[7]];
          buffer[0] = cnt[7:0];
          buffer[1] = cnt[15:8];
          retire(CMDB_STREAM);
        end
        CMD_SET_BLOCK: begin
          cur_block = {buffer[1], buffer[0]};
          buffer[0] = 8'h00;   // status byte
          retire(CMDB_STREAM);
        end
        CMD_READ, CMD_READ0: begin
          if (cmd_byte[3:0] == CMD_READ0) cur_block = '0;
          base = block_base(cmd_byte[7]);
          for (int i = 0; i < BUFFER_BYTES; i++) buffer[i] = disk[base + i];
          transfers++;
          retire(CMDB_STREAM);
        end
        CMD_WRITE: begin
          base = block_base(cmd_byte[7]);
          for (int i = 0; i < BUFFER_BYTES; i++) disk[base + i] = buffer[i];
          transfers++;
          retire(CMDB_NONE);
        end
        CMD_CLEAR: begin
          // unit one if any high-nibble bit is set, unlike the other commands
          base = block_base(cmd_byte[7:4] != 4'h0);
          for (int i = 0; i < BUFFER_BYTES; i++) begin
            buffer[i]      = 8'h00;
            disk[base + i] = 8'h00;
          end
          transfers++;
          retire(CMDB_STREAM);
        end
        CMD_FIFO_RST: if (cmd_pend) retire(CMDB_NONE);
        CMD_STREAM: if (!rd_ready) begin
          rd_latch = buffer[idx];
          rd_ready = 1'b1;
          idx      = idx + 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void note_access(input logic [3:0] addr, input logic [7:0] data);
      logic [7:0] ret;
      ret = 8'h00;
      case (addr)
        REG_WR_DATA:  wr_latch = data;
        REG_WR_PEND:  wr_pend = 1'b1;
        REG_RD_DATA:  ret = rd_latch;
        REG_RD_CLR:   rd_ready = 1'b0;
        REG_POLL_CMD: begin
          ret = cmd_pend ? FLAG_SET : FLAG_CLR;
          run_command();
        end
        REG_POLL_WR: begin
          ret = wr_pend ? FLAG_SET : FLAG_CLR;
          run_command();
        end
        REG_POLL_RD: begin
          ret = rd_ready ? FLAG_SET : FLAG_CLR;
          run_command();
        end
        REG_CMD: begin
          cmd_byte = data;
          idx      = '0;
          cmd_pend = 1'b1;
          wr_pend  = 1'b0;
          rd_ready = 1'b0;
        end
        default: ;
      endcase
      read_data_due.push_back(ret);
    endfunction

    function void check_read_data(input logic [7:0] actual);
      logic [7:0] want;
      if (read_data_due.size() == 0) begin
        errors++;
        $error("read_data: no transaction outstanding, actual %02h", actual);
        return;
      end
      want = read_data_due.pop_front();
      results++;
      if (actual !== want) begin
        errors++;
        $error("read_data mismatch: expected %02h, actual %02h", want, actual);
      end
    endfunction
  endclass

  disk_latch_scoreboard sb;

  block_disk_latch_controller_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .reg_addr_i  (reg_addr_i),
    .bus_data_i  (bus_data_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // any of the three status registers; each one steps the command
  function automatic logic [3:0] any_poll();
    return REG_POLL_CMD + 4'($urandom_range(0, 2));
  endfunction

  // One transaction: start stays up until accepted (start high, busy low).
  // Start is left high when the next transaction follows with no gap.
  task automatic access(input logic [3:0] addr, input logic [7:0] data);
    int gap;
    start_i    <= 1'b1;
    reg_addr_i <= addr;
    bus_data_i <= data;
    do @(posedge clk_i); while (busy_o);
    if (!addr[3]) n_items++;
    gap = gap_len();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic poll(input logic [3:0] addr);
    access(addr, 8'($urandom));
  endtask

  task automatic load_cmd(input logic [7:0] cmd);
    access(REG_CMD, cmd);
  endtask

  // byte into the buffer: latch, mark pending, then a poll moves it (idle command)
  task automatic push_byte(input logic [7:0] b);
    access(REG_WR_DATA, b);
    poll(REG_WR_PEND);
    poll(any_poll());
  endtask

  // stream bytes out: poll steps the stream, read the latch, then release it
  task automatic pull_bytes(input int n);
    repeat (n) begin
      poll(any_poll());
      poll(REG_RD_DATA);
      poll(REG_RD_CLR);
    end
  endtask

  // latch a command, step it once, sometimes poll again to see the flag drop
  task automatic run_disk_cmd(input logic [7:0] cmd);
    load_cmd(cmd);
    poll(REG_POLL_CMD);
    if ($urandom_range(0, 1) != 0) poll(any_poll());
  endtask

  // Block number goes through buffer bytes 0/1 and the set-block command.
  // Mostly a few low blocks so data written earlier is read back, some
  // aliases above the disk depth, and some fully random numbers.
  task automatic select_block();
    logic [15:0] blk;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 70) blk = 16'($urandom_range(0, 7));
    else if (r < 90) blk = 16'($urandom_range(0, 7) + DISK_BLOCKS * $urandom_range(1, 511));
    else blk = 16'($urandom);
    load_cmd({4'($urandom_range(0, 15)), CMD_IDLE});
    push_byte(blk[7:0]);
    push_byte(blk[15:8]);
    run_disk_cmd({4'($urandom_range(0, 15)), CMD_SET_BLOCK});
  endtask

  // drop start and wait until every result is in and the block is idle
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.read_data_due.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_block_count(input logic unit, input logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= unit;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_count(unit, value);
  endtask

  // One random sequence. Most are well-formed disk operations with random
  // content and unit bits; the rest is noise and arbitrary command bytes.
  task automatic random_sequence();
    int         pick;
    logic [3:0] hi;
    gaps_on = ($urandom_range(0, 3) != 0);
    hi      = 4'($urandom_range(0, 15));
    pick    = $urandom_range(0, 99);
    if (pick < 24) begin
      // fill a few buffer bytes and write the block
      select_block();
      load_cmd({4'($urandom_range(0, 15)), CMD_IDLE});
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      run_disk_cmd({hi, CMD_WRITE});
    end else if (pick < 48) begin
      select_block();
      run_disk_cmd({hi, CMD_READ});
      pull_bytes(($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(20, 60));
    end else if (pick < 56) begin
      run_disk_cmd({hi, CMD_READ0});
      pull_bytes($urandom_range(1, 6));
    end else if (pick < 63) begin
      select_block();
      run_disk_cmd({hi, CMD_CLEAR});
      pull_bytes($urandom_range(1, 3));
    end else if (pick < 71) begin
      run_disk_cmd({hi, CMD_SIZE});
      pull_bytes($urandom_range(2, 3));
    end else if (pick < 77) begin
      load_cmd({hi, CMD_FIFO_RST});
      repeat ($urandom_range(1, 3)) poll(any_poll());
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 4)) access(4'($urandom), 8'($urandom));
    end else begin
      // arbitrary command byte, unknown codes included, then random polls/reads
      load_cmd(8'($urandom));
      repeat ($urandom_range(1, 4)) poll(4'($urandom_range(0, 7)));
    end
  endtask

  // Result monitor: values sampled at the edge, before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_read_data(read_data_o);
      if (start_i && !busy_o) sb.note_access(reg_addr_i, bus_data_i);
    end
  end

  // Watchdog: any accepted transaction or result restarts the count.
  always @(posedge clk_i) begin
    if ((rst_ni && start_i && !busy_o) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("block_disk_latch_controller_top regression: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes first; settle also rides out the post-reset buffer clear
    set_block_count(CFG_UNIT0, 16'h0000);
    set_block_count(CFG_UNIT1, 16'hFFFF);

    // directed: unused offsets, idle polls, byte pushes at both extremes,
    // size of unit one, clear selected by a non-top high-nibble bit,
    // FIFO reset with a pending command, unknown command code
    access(4'hF, 8'hFF);
    access(4'h8, 8'h00);
    poll(REG_POLL_CMD);
    poll(REG_POLL_WR);
    poll(REG_POLL_RD);
    push_byte(8'hFF);
    push_byte(8'h00);
    run_disk_cmd({4'h8, CMD_SIZE});
    pull_bytes(2);
    load_cmd({4'h1, CMD_CLEAR});
    poll(REG_POLL_CMD);
    load_cmd({4'h0, CMD_FIFO_RST});
    poll(REG_POLL_CMD);
    poll(REG_POLL_CMD);
    load_cmd({4'h0, 4'hB});
    poll(REG_POLL_WR);

    // random phases, each under its own pair of block counts
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          set_block_count(CFG_UNIT0, 16'hFFFF);
          set_block_count(CFG_UNIT1, 16'h0000);
        end
        2: begin
          set_block_count(CFG_UNIT0, 16'd128);
          set_block_count(CFG_UNIT1, 16'd128);
        end
        4: begin
          set_block_count(CFG_UNIT0, 16'h0001);
          set_block_count(CFG_UNIT1, 16'hFFFE);
        end
        default: begin
          set_block_count(CFG_UNIT0, 16'($urandom));
          set_block_count(CFG_UNIT1, 16'($urandom));
        end
      endcase
      while (n_items < ITEM_TARGET * (phase + 1) / PHASES) random_sequence();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.read_data_due.size() != 0) begin
      sb.errors += sb.read_data_due.size();
      $error("read_data: %0d results never arrived, oldest expected %02h",
             sb.read_data_due.size(), sb.read_data_due[0]);
    end

    $display("Ran %0d register transactions over %0d block-count settings, %0d results checked;",
             n_items, PHASES + 1, sb.results);
    $display("%0d block reads, writes and clears went through the disk store.", sb.transfers);
    if (sb.errors == 0) begin
      $display("block_disk_latch_controller_top regression: pass");
    end else begin
      $display("block_disk_latch_controller_top regression: fail");
    end
    $finish;
  end

endmodule
